// ----- rtl/telemetry_response_deframer_assert.svh -----
// Assertion macros for the telemetry response deframer.
`ifndef TELEMETRY_RESPONSE_DEFRAMER_ASSERT_SVH
`define TELEMETRY_RESPONSE_DEFRAMER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define TRD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define TRD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/trd_pkg.sv -----
// Package: types and constants of the telemetry response deframer.
package trd_pkg;

  localparam int unsigned TimeoutWidth = 16;
  localparam logic [TimeoutWidth-1:0] TimeoutReset = 16'd200;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_TICK = 2'd1,
    KIND_POLL = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_DECODED  = 2'd0,
    ST_TIMEOUT  = 2'd1,
    ST_UNKNOWN  = 2'd2
  } status_t;

  localparam logic [7:0] CmdPower = 8'd1;
  localparam logic [7:0] CmdMotor = 8'd2;
  localparam logic [7:0] CmdGps   = 8'd3;
  localparam logic [7:0] CmdNone  = 8'd0;

  typedef enum logic [1:0] {
    PH_CMD,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_PAYLOAD
  } phase_t;

endpackage

// ----- rtl/telemetry_response_deframer.sv -----
// Top level: telemetry response packet deframer with header timeout.
//
//  channel | handshake          | payload
//  --------+--------------------+-------------------------------------------
//  in      | in_valid/in_ready  | kind, rx_byte
//  out     | out_valid/out_ready| status, command, voltage..gps_time_word
//  cfg     | cfg_wr_en          | cfg_wr_data (timeout_ticks)
//
// One beat per cycle while no result waits downstream: an input register feeds a
// single decode step that writes the state and the result register.
// While a result waits downstream the input register takes one more beat,
// then in_ready drops.
// A stalled result holds the decode step; field ports change only on a step.
// Reset is synchronous; no clearing pass is needed.
`include "telemetry_response_deframer_assert.svh"

module telemetry_response_deframer
  import trd_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_wr_en,
  input  logic [TimeoutWidth-1:0] cfg_wr_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              kind,
  input  logic [7:0]              rx_byte,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [1:0]              status,
  output logic [7:0]              command,
  output logic [7:0]              voltage_one,
  output logic [7:0]              voltage_two,
  output logic [7:0]              current_level,
  output logic [15:0]             rpm_value,
  output logic [15:0]             temperature_value,
  output logic [63:0]             latitude_bits,
  output logic [63:0]             longitude_bits,
  output logic [63:0]             speed_bits,
  output logic [31:0]             gps_date_word,
  output logic [31:0]             gps_time_word
);

  logic [TimeoutWidth-1:0] timeout_ticks;

  logic       hold_valid;
  logic [1:0] hold_kind;
  logic [7:0] hold_byte;

  phase_t                  phase, phase_next;
  logic                    armed, armed_next;
  logic [TimeoutWidth-1:0] tick_count, tick_next;
  logic [7:0]              cmd_reg, cmd_next;
  logic [15:0]             payload_length, len_next;
  logic [15:0]             byte_index, index_next;
  logic [63:0]             assembly_reg, assembly_next;

  logic       emit;
  logic [1:0] status_next;
  logic [7:0] command_next;

  logic [7:0]  voltage_one_next, voltage_two_next, current_level_next;
  logic [15:0] rpm_next, temperature_next;
  logic [63:0] latitude_next, longitude_next, speed_next;
  logic [31:0] date_next, time_next;

  logic                    fire;
  logic                    is_byte;
  logic                    timeout_hit;
  logic [TimeoutWidth-1:0] tick_inc;
  logic [15:0]             index_inc;
  logic                    known_cmd;
  logic [2:0]              gps_k;
  logic                    gps_last;
  logic [63:0]             gps_base;
  logic [63:0]             gps_word;

  assign fire     = hold_valid && (!out_valid || out_ready);
  assign in_ready = !hold_valid || fire;
  assign is_byte  = (hold_kind == KIND_BYTE);

  assign tick_inc    = (tick_count == '1) ? tick_count : tick_count + 1'b1;
  assign timeout_hit = (hold_kind == KIND_TICK) && armed && (tick_inc >= timeout_ticks);
  assign index_inc   = byte_index + 16'd1;
  assign known_cmd   = (cmd_reg == CmdPower) || (cmd_reg == CmdMotor) || (cmd_reg == CmdGps);

  assign gps_k    = (byte_index < 16'd24) ? byte_index[2:0] : {1'b0, byte_index[1:0]};
  assign gps_last = (byte_index < 16'd24) ? (byte_index[2:0] == 3'd7)
                                          : (byte_index[1:0] == 2'd3);
  assign gps_base = (gps_k == 3'd0) ? 64'd0 : assembly_reg;
  assign gps_word = gps_base | ({56'd0, hold_byte} << {gps_k, 3'b000});

  // Control: phase, timer, header and result.
  always_comb begin
    phase_next   = phase;
    armed_next   = armed;
    tick_next    = tick_count;
    cmd_next     = cmd_reg;
    len_next     = payload_length;
    index_next   = byte_index;
    emit         = 1'b0;
    status_next  = ST_DECODED;
    command_next = cmd_reg;
    case (hold_kind)
      KIND_POLL: begin
        armed_next = 1'b1;
        tick_next  = '0;
      end
      KIND_TICK: begin
        if (armed) begin
          tick_next = tick_inc;
          if (timeout_hit) begin
            armed_next   = 1'b0;
            tick_next    = '0;
            phase_next   = PH_CMD;
            index_next   = '0;
            emit         = 1'b1;
            status_next  = ST_TIMEOUT;
            command_next = CmdNone;
          end
        end
      end
      KIND_BYTE: begin
        case (phase)
          PH_CMD: begin
            cmd_next   = hold_byte;
            phase_next = PH_LEN_HI;
          end
          PH_LEN_HI: begin
            len_next   = {hold_byte, 8'd0};
            phase_next = PH_LEN_LO;
          end
          PH_LEN_LO: begin
            len_next   = {payload_length[15:8], hold_byte};
            armed_next = 1'b0;
            tick_next  = '0;
            index_next = '0;
            if ({payload_length[15:8], hold_byte} == 16'd0) begin
              phase_next  = PH_CMD;
              emit        = 1'b1;
              status_next = known_cmd ? ST_DECODED : ST_UNKNOWN;
            end else begin
              phase_next = PH_PAYLOAD;
            end
          end
          PH_PAYLOAD: begin
            index_next = index_inc;
            if (index_inc >= payload_length) begin
              phase_next  = PH_CMD;
              index_next  = '0;
              emit        = 1'b1;
              status_next = known_cmd ? ST_DECODED : ST_UNKNOWN;
            end
          end
          default: begin
            phase_next = PH_CMD;
          end
        endcase
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // Datapath: field assembly.
  always_comb begin
    assembly_next      = assembly_reg;
    voltage_one_next   = voltage_one;
    voltage_two_next   = voltage_two;
    current_level_next = current_level;
    rpm_next           = rpm_value;
    temperature_next   = temperature_value;
    latitude_next      = latitude_bits;
    longitude_next     = longitude_bits;
    speed_next         = speed_bits;
    date_next          = gps_date_word;
    time_next          = gps_time_word;
    if (is_byte && phase == PH_PAYLOAD) begin
      case (cmd_reg)
        CmdPower: begin
          if (byte_index == 16'd0) voltage_one_next = hold_byte;
          if (byte_index == 16'd1) voltage_two_next = hold_byte;
          if (byte_index == 16'd2) current_level_next = hold_byte;
        end
        CmdMotor: begin
          if (byte_index < 16'd4) begin
            assembly_next = {48'd0, assembly_reg[7:0], hold_byte};
            if (byte_index == 16'd1) rpm_next = {assembly_reg[7:0], hold_byte};
            if (byte_index == 16'd3) temperature_next = {assembly_reg[7:0], hold_byte};
          end
        end
        CmdGps: begin
          if (byte_index < 16'd32) begin
            assembly_next = gps_word;
            if (gps_last) begin
              case (byte_index[4:3])
                2'd0:    latitude_next = gps_word;
                2'd1:    longitude_next = gps_word;
                2'd2:    speed_next = gps_word;
                default: begin
                  if (byte_index[2]) time_next = gps_word[31:0];
                  else date_next = gps_word[31:0];
                end
              endcase
            end
          end
        end
        default: begin
          assembly_next = assembly_reg;
        end
      endcase
    end
    // clear on header end, packet end and timeout
    if ((is_byte && (phase == PH_LEN_LO || phase_next == PH_CMD) && phase != PH_CMD)
        || timeout_hit) begin
      assembly_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TimeoutReset;
    end else if (cfg_wr_en) begin
      timeout_ticks <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_kind <= kind;
      hold_byte <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_CMD;
      armed             <= 1'b0;
      tick_count        <= '0;
      cmd_reg           <= '0;
      payload_length    <= '0;
      byte_index        <= '0;
      assembly_reg      <= '0;
      voltage_one       <= '0;
      voltage_two       <= '0;
      current_level     <= '0;
      rpm_value         <= '0;
      temperature_value <= '0;
      latitude_bits     <= '0;
      longitude_bits    <= '0;
      speed_bits        <= '0;
      gps_date_word     <= '0;
      gps_time_word     <= '0;
    end else if (fire) begin
      phase             <= phase_next;
      armed             <= armed_next;
      tick_count        <= tick_next;
      cmd_reg           <= cmd_next;
      payload_length    <= len_next;
      byte_index        <= index_next;
      assembly_reg      <= assembly_next;
      voltage_one       <= voltage_one_next;
      voltage_two       <= voltage_two_next;
      current_level     <= current_level_next;
      rpm_value         <= rpm_next;
      temperature_value <= temperature_next;
      latitude_bits     <= latitude_next;
      longitude_bits    <= longitude_next;
      speed_bits        <= speed_next;
      gps_date_word     <= date_next;
      gps_time_word     <= time_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      status  <= status_next;
      command <= command_next;
    end
  end

  `TRD_ASSERT_NOW(a_timeout_cmd, clk, rst,
                  out_valid && status == ST_TIMEOUT, command == CmdNone,
                  "timeout result carries a command")
  `TRD_ASSERT_NEXT(a_emit_valid, clk, rst, fire && emit, out_valid,
                   "result lost after decode step")
  `TRD_ASSERT_NEXT(a_timeout_clear, clk, rst, fire && timeout_hit,
                   phase == PH_CMD && !armed && tick_count == '0,
                   "timeout left packet or timer state")
  `TRD_ASSERT_NOW(a_index_range, clk, rst, phase == PH_PAYLOAD, byte_index < payload_length,
                  "payload index past length")

endmodule

// ----- tb/tb_telemetry_response_deframer.sv -----
// Testbench for the telemetry response deframer: directed and random packets, polls and ticks.
`timescale 1ns / 100ps

module tb_telemetry_response_deframer;
  import trd_pkg::*;

  localparam logic [1:0] KIND_SPARE = 2'd3;
  localparam int unsigned QuietLimit = 4000;
  localparam int unsigned HoldoffCycles = 300;

  typedef struct {
    logic [1:0] kind_code;
    logic [7:0] data;
  } beat_t;

  typedef struct {
    logic [7:0]  voltage_one;
    logic [7:0]  voltage_two;
    logic [7:0]  current_level;
    logic [15:0] rpm_value;
    logic [15:0] temperature_value;
    logic [63:0] latitude_bits;
    logic [63:0] longitude_bits;
    logic [63:0] speed_bits;
    logic [31:0] gps_date_word;
    logic [31:0] gps_time_word;
  } telemetry_fields_t;

  typedef struct {
    status_t           status;
    logic [7:0]        command;
    telemetry_fields_t fields;
  } deframe_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [TimeoutWidth-1:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] kind = 2'd0;
  logic [7:0] rx_byte = 8'd0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] status;
  logic [7:0] command;
  logic [7:0] voltage_one;
  logic [7:0] voltage_two;
  logic [7:0] current_level;
  logic [15:0] rpm_value;
  logic [15:0] temperature_value;
  logic [63:0] latitude_bits;
  logic [63:0] longitude_bits;
  logic [63:0] speed_bits;
  logic [31:0] gps_date_word;
  logic [31:0] gps_time_word;

  beat_t pending_beats[$];
  deframe_result_t expected_results[$];
  int unsigned beats_queued = 0;
  int unsigned mismatches = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  int unsigned holdoff_left = 0;
  int unsigned holdoff_requests = 0;
  int unsigned holdoffs_served = 0;
  int unsigned quiet_cycles = 0;

  logic [15:0] timeout_limit = TimeoutReset;
  phase_t rx_phase = PH_CMD;
  logic tmr_armed = 1'b0;
  logic [15:0] tmr_count = '0;
  logic [7:0] pkt_cmd = '0;
  logic [15:0] pkt_len = '0;
  logic [15:0] payload_pos = '0;
  logic [63:0] field_acc = '0;
  telemetry_fields_t latest = '{default: '0};

  always #10 clk = ~clk;

  telemetry_response_deframer i_dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .kind             (kind),
    .rx_byte          (rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .status           (status),
    .command          (command),
    .voltage_one      (voltage_one),
    .voltage_two      (voltage_two),
    .current_level    (current_level),
    .rpm_value        (rpm_value),
    .temperature_value(temperature_value),
    .latitude_bits    (latitude_bits),
    .longitude_bits   (longitude_bits),
    .speed_bits       (speed_bits),
    .gps_date_word    (gps_date_word),
    .gps_time_word    (gps_time_word)
  );

  task automatic emit_result(input status_t st, input logic [7:0] cmd);
    deframe_result_t res;
    res.status = st;
    res.command = cmd;
    res.fields = latest;
    expected_results.push_back(res);
  endtask

  task automatic store_payload(input logic [15:0] pos, input logic [7:0] b);
    int unsigned field_base;
    int unsigned last_sub;
    int unsigned sub;
    case (pkt_cmd)
      CmdPower: begin
        if (pos == 0) latest.voltage_one = b;
        else if (pos == 1) latest.voltage_two = b;
        else if (pos == 2) latest.current_level = b;
      end
      CmdMotor: begin
        if (pos < 4) begin
          field_acc = {48'd0, field_acc[7:0], b};
          if (pos == 1) latest.rpm_value = field_acc[15:0];
          else if (pos == 3) latest.temperature_value = field_acc[15:0];
        end
      end
      CmdGps: begin
        if (pos < 32) begin
          if (pos < 24) begin
            field_base = 32'({pos[15:3], 3'b000});
            last_sub = 7;
          end else if (pos < 28) begin
            field_base = 24;
            last_sub = 3;
          end else begin
            field_base = 28;
            last_sub = 3;
          end
          sub = 32'(pos) - field_base;
          if (sub == 0) field_acc = '0;
          field_acc |= 64'(b) << (8 * sub);
          if (sub == last_sub) begin
            if (pos < 8) latest.latitude_bits = field_acc;
            else if (pos < 16) latest.longitude_bits = field_acc;
            else if (pos < 24) latest.speed_bits = field_acc;
            else if (pos < 28) latest.gps_date_word = field_acc[31:0];
            else latest.gps_time_word = field_acc[31:0];
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic finish_packet();
    rx_phase = PH_CMD;
    payload_pos = '0;
    field_acc = '0;
    emit_result((pkt_cmd >= CmdPower && pkt_cmd <= CmdGps) ? ST_DECODED : ST_UNKNOWN,
                pkt_cmd);
  endtask

  task automatic deframe_step(input logic [1:0] k, input logic [7:0] b);
    case (k)
      KIND_POLL: begin
        tmr_armed = 1'b1;
        tmr_count = '0;
      end
      KIND_TICK: begin
        if (tmr_armed) begin
          if (tmr_count != 16'hFFFF) tmr_count++;
          if (tmr_count >= timeout_limit) begin
            tmr_armed = 1'b0;
            tmr_count = '0;
            rx_phase = PH_CMD;
            payload_pos = '0;
            field_acc = '0;
            emit_result(ST_TIMEOUT, CmdNone);
          end
        end
      end
      KIND_BYTE: begin
        case (rx_phase)
          PH_CMD: begin
            pkt_cmd = b;
            rx_phase = PH_LEN_HI;
          end
          PH_LEN_HI: begin
            pkt_len = {b, 8'h00};
            rx_phase = PH_LEN_LO;
          end
          PH_LEN_LO: begin
            pkt_len[7:0] = b;
            tmr_armed = 1'b0;
            tmr_count = '0;
            payload_pos = '0;
            field_acc = '0;
            if (pkt_len == 0) finish_packet();
            else rx_phase = PH_PAYLOAD;
          end
          default: begin
            store_payload(payload_pos, b);
            payload_pos++;
            if (payload_pos >= pkt_len) finish_packet();
          end
        endcase
      end
      default: ;
    endcase
  endtask

  function automatic bit field_differs(input string name, input logic [63:0] got,
                                       input logic [63:0] want, input bit report);
    if (got !== want) begin
      if (report) $display("%0t mismatch %s: expected %h, got %h", $time, name, want, got);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic push_beat(input logic [1:0] k, input logic [7:0] b);
    pending_beats.push_back('{k, b});
    beats_queued++;
  endtask

  task automatic push_header(input logic [7:0] cmd, input logic [15:0] len);
    push_beat(KIND_BYTE, cmd);
    push_beat(KIND_BYTE, len[15:8]);
    push_beat(KIND_BYTE, len[7:0]);
  endtask

  task automatic push_packet(input logic [7:0] cmd, input logic [15:0] len, input bit polled);
    bit tick_ok;
    tick_ok = polled && timeout_limit > 2;
    if (polled) push_beat(KIND_POLL, 8'($urandom_range(0, 255)));
    push_beat(KIND_BYTE, cmd);
    if (tick_ok && $urandom_range(0, 99) < 30) push_beat(KIND_TICK, 8'($urandom_range(0, 255)));
    push_beat(KIND_BYTE, len[15:8]);
    if (tick_ok && $urandom_range(0, 99) < 30) push_beat(KIND_TICK, 8'($urandom_range(0, 255)));
    push_beat(KIND_BYTE, len[7:0]);
    for (int unsigned i = 0; i < len; i++) begin
      push_beat(KIND_BYTE, 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 99) < 10) push_beat(KIND_TICK, 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic push_random_packet();
    int unsigned r;
    logic [7:0] cmd;
    logic [15:0] len;
    r = $urandom_range(0, 99);
    if (r < 25) cmd = CmdPower;
    else if (r < 50) cmd = CmdMotor;
    else if (r < 80) cmd = CmdGps;
    else if (r < 85) cmd = CmdNone;
    else cmd = 8'($urandom_range(4, 255));
    case (cmd)
      CmdPower: len = 16'($urandom_range(0, 5));
      CmdMotor: len = 16'($urandom_range(0, 6));
      CmdGps: len = 16'(($urandom_range(0, 99) < 60) ? $urandom_range(32, 35)
                                                      : $urandom_range(0, 31));
      default: len = 16'($urandom_range(0, 6));
    endcase
    push_packet(cmd, len, 1'($urandom_range(0, 1)));
  endtask

  task automatic gen_traffic(input int unsigned count);
    int unsigned goal;
    int unsigned pick;
    goal = beats_queued + count;
    while (beats_queued < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 62) begin
        push_random_packet();
      end else if (pick < 74) begin
        push_beat(KIND_POLL, 8'($urandom_range(0, 255)));
        repeat ($urandom_range(1, 8)) push_beat(KIND_TICK, 8'($urandom_range(0, 255)));
      end else if (pick < 84) begin
        if (timeout_limit <= 16) begin
          push_beat(KIND_POLL, 8'($urandom_range(0, 255)));
          push_beat(KIND_BYTE, 8'($urandom_range(0, 255)));
          if ($urandom_range(0, 1)) push_beat(KIND_BYTE, 8'($urandom_range(0, 255)));
          repeat ((timeout_limit == 0) ? 1 : timeout_limit)
            push_beat(KIND_TICK, 8'($urandom_range(0, 255)));
        end else begin
          push_random_packet();
        end
      end else if (pick < 94) begin
        push_beat(KIND_TICK, 8'($urandom_range(0, 255)));
      end else begin
        push_beat(KIND_SPARE, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_beats.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_timeout(input logic [15:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    timeout_limit = value;
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    beat_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) deframe_step(kind, rx_byte);
      if (!in_valid || in_ready) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_beats.size() != 0) begin
          nxt = pending_beats.pop_front();
          in_valid <= 1'b1;
          kind <= nxt.kind_code;
          rx_byte <= nxt.data;
          if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)
            send_gap = $urandom_range(1, 13);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    deframe_result_t want;
    bit bad;
    bit report;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        report = (mismatches < 10);
        if (expected_results.size() == 0) begin
          if (report) $display("%0t unexpected result: status %0d command %h",
                               $time, status, command);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          bad = 1'b0;
          bad |= field_differs("status", 64'(status), 64'(want.status), report);
          bad |= field_differs("command", 64'(command), 64'(want.command), report);
          bad |= field_differs("voltage_one", 64'(voltage_one),
                               64'(want.fields.voltage_one), report);
          bad |= field_differs("voltage_two", 64'(voltage_two),
                               64'(want.fields.voltage_two), report);
          bad |= field_differs("current_level", 64'(current_level),
                               64'(want.fields.current_level), report);
          bad |= field_differs("rpm_value", 64'(rpm_value),
                               64'(want.fields.rpm_value), report);
          bad |= field_differs("temperature_value", 64'(temperature_value),
                               64'(want.fields.temperature_value), report);
          bad |= field_differs("latitude_bits", latitude_bits,
                               want.fields.latitude_bits, report);
          bad |= field_differs("longitude_bits", longitude_bits,
                               want.fields.longitude_bits, report);
          bad |= field_differs("speed_bits", speed_bits, want.fields.speed_bits, report);
          bad |= field_differs("gps_date_word", 64'(gps_date_word),
                               64'(want.fields.gps_date_word), report);
          bad |= field_differs("gps_time_word", 64'(gps_time_word),
                               64'(want.fields.gps_time_word), report);
          if (bad) mismatches++;
        end
      end
      if (holdoffs_served != holdoff_requests) begin
        holdoffs_served++;
        holdoff_left = HoldoffCycles;
      end
      if (holdoff_left != 0) begin
        holdoff_left--;
        out_ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (recv_idle_pct != 0 && $urandom_range(0, 99) < recv_idle_pct) begin
        stall_left = $urandom_range(0, 12);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("tb_telemetry_response_deframer: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_idle_pct = 20;
    recv_idle_pct = 20;
    push_header(CmdPower, 16'd3);
    push_beat(KIND_BYTE, 8'hFF);
    push_beat(KIND_BYTE, 8'h00);
    push_beat(KIND_BYTE, 8'h5A);
    push_header(CmdMotor, 16'd3);
    push_beat(KIND_BYTE, 8'hFF);
    push_beat(KIND_BYTE, 8'hFF);
    push_beat(KIND_BYTE, 8'h12);
    push_header(CmdNone, 16'd0);
    push_beat(KIND_SPARE, 8'hFF);
    push_beat(KIND_POLL, 8'h00);
    push_beat(KIND_BYTE, 8'hFF);
    push_beat(KIND_TICK, 8'hAA);
    push_beat(KIND_BYTE, 8'h00);
    push_beat(KIND_BYTE, 8'h01);
    push_beat(KIND_BYTE, 8'h77);
    push_header(CmdPower, 16'd0);
    wait_drained();

    write_timeout(16'd1);
    push_beat(KIND_POLL, 8'h00);
    push_beat(KIND_TICK, 8'h00);
    push_beat(KIND_POLL, 8'h00);
    push_beat(KIND_BYTE, CmdGps);
    push_beat(KIND_BYTE, 8'hFF);
    push_beat(KIND_TICK, 8'h00);
    gen_traffic(150);
    wait_drained();

    write_timeout(16'd0);
    send_idle_pct = 30;
    recv_idle_pct = 10;
    gen_traffic(150);
    wait_drained();

    write_timeout(16'hFFFF);
    send_idle_pct = 10;
    recv_idle_pct = 0;
    holdoff_requests++;
    push_packet(CmdPower, 16'h0101, 1'b1);
    gen_traffic(100);
    wait_drained();

    write_timeout(16'($urandom_range(2, 40)));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    gen_traffic(120);
    wait_drained();

    write_timeout(16'd3);
    send_idle_pct = 35;
    recv_idle_pct = 35;
    gen_traffic(120);
    wait_drained();

    write_timeout(TimeoutReset);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    gen_traffic(120);
    wait_drained();

    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("tb_telemetry_response_deframer: done, clean");
    end else begin
      $display("tb_telemetry_response_deframer: done, errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/trd_pkg.sv
rtl/telemetry_response_deframer.sv
tb/tb_telemetry_response_deframer.sv
